### design/polar_goal_pose_controller_macros.svh
// Assertion macros for the polar goal pose controller.
`ifndef POLAR_GOAL_POSE_CONTROLLER_MACROS_SVH
`define POLAR_GOAL_POSE_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define PGPC_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("pgpc: assertion failed");
// Checked on every edge, reset included.
`define PGPC_ASSERT_RST(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("pgpc: reset check failed");
`else
`define PGPC_ASSERT(lbl, clk_s, rstn_s, prop)
`define PGPC_ASSERT_RST(lbl, clk_s, prop)
`endif
`endif

### design/pgpc_pkg.sv
`default_nettype none
package pgpc_pkg;

  // CORDIC x/y datapath width: |ex|,|ey| < 2^16, scaled by 256, gain 1.65
  localparam int CW        = 28;
  localparam int ATAN_LEN  = 24;
  // one square root digit per cell: 17 result bits
  localparam int SQ_DIGITS = 17;

  // pi in Q2.29
  localparam logic signed [31:0] PI_Q29 = 32'sd1686629713;

  // register indexes
  localparam logic [2:0] REG_GOAL_X       = 3'd0;
  localparam logic [2:0] REG_GOAL_Y       = 3'd1;
  localparam logic [2:0] REG_GOAL_HEADING = 3'd2;
  localparam logic [2:0] REG_GAIN_RHO     = 3'd3;
  localparam logic [2:0] REG_GAIN_ALPHA   = 3'd4;
  localparam logic [2:0] REG_GAIN_BETA    = 3'd5;
  localparam logic [2:0] REG_POS_TOL      = 3'd6;
  localparam logic [2:0] REG_ANG_TOL      = 3'd7;

  // reset values
  localparam logic signed [15:0] RST_GAIN_RHO   = 16'sd614;
  localparam logic signed [15:0] RST_GAIN_ALPHA = 16'sd1638;
  localparam logic signed [15:0] RST_GAIN_BETA  = -16'sd614;
  localparam logic [14:0]        RST_POS_TOL    = 15'd102;
  localparam logic [14:0]        RST_ANG_TOL    = 15'd10430;

  typedef struct packed {
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [15:0] pose_heading;
  } in_t;

  typedef struct packed {
    logic [16:0]        linear_speed;
    logic signed [15:0] angular_speed;
    logic [16:0]        distance;
    logic signed [15:0] bearing_error;
    logic signed [15:0] heading_error;
    logic               at_goal;
  } out_t;

  typedef struct packed {
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic signed [15:0] goal_heading;
    logic signed [15:0] gain_rho;
    logic signed [15:0] gain_alpha;
    logic signed [15:0] gain_beta;
    logic [14:0]        position_tolerance;
    logic [14:0]        angle_tolerance;
  } cfg_t;

  // one beat moving down the cell row
  typedef struct packed {
    logic                 vld;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
    logic [33:0]          sq_n;
    logic [33:0]          sq_res;
    logic signed [15:0]   heading;
    logic signed [15:0]   beta;
    logic                 arrived;
    logic                 zero;
  } cell_t;

  // atan(2^-i), 2^32 = 2*pi, rounded to nearest
  function automatic logic [31:0] atan_entry(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2FA;
      15:      v = 32'h0000517D;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A30;
      19:      v = 32'h00000518;
      20:      v = 32'h0000028C;
      21:      v = 32'h00000146;
      22:      v = 32'h000000A3;
      23:      v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // square root trial bit for a cell: 4^(SQ_DIGITS-1-idx)
  function automatic logic [33:0] sq_bit(input int unsigned idx);
    logic [33:0] v;
    v = '0;
    if (idx < SQ_DIGITS) begin
      v[2*(SQ_DIGITS-1-idx)] = 1'b1;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

### design/pgpc_cell.sv
`default_nettype none
// One CORDIC vectoring micro-rotation (when ROT_EN) plus one square root digit (when IDX is below SQ_DIGITS).
module pgpc_cell #(
  parameter int IDX    = 0,
  parameter bit ROT_EN = 1'b1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire pgpc_pkg::cell_t cell_in,
  output pgpc_pkg::cell_t      cell_out
);

  localparam bit          SQ_EN  = (IDX < pgpc_pkg::SQ_DIGITS);
  localparam logic [33:0] SQ_BIT = pgpc_pkg::sq_bit(IDX);
  localparam logic [31:0] ATAN   = pgpc_pkg::atan_entry(IDX);

  pgpc_pkg::cell_t cell_r;
  pgpc_pkg::cell_t cell_nxt;

  always_comb begin
    logic signed [pgpc_pkg::CW-1:0] xs;
    logic signed [pgpc_pkg::CW-1:0] ys;
    logic [33:0]                    trial;
    cell_nxt = cell_in;
    xs       = cell_in.x >>> IDX;
    ys       = cell_in.y >>> IDX;
    trial    = cell_in.sq_res + SQ_BIT;
    if (ROT_EN) begin
      if (!cell_in.y[pgpc_pkg::CW-1]) begin
        cell_nxt.x = cell_in.x + ys;
        cell_nxt.y = cell_in.y - xs;
        cell_nxt.z = cell_in.z + ATAN;
      end else begin
        cell_nxt.x = cell_in.x - ys;
        cell_nxt.y = cell_in.y + xs;
        cell_nxt.z = cell_in.z - ATAN;
      end
    end
    if (SQ_EN) begin
      if (cell_in.sq_n >= trial) begin
        cell_nxt.sq_n   = cell_in.sq_n - trial;
        cell_nxt.sq_res = (cell_in.sq_res >> 1) + SQ_BIT;
      end else begin
        cell_nxt.sq_res = cell_in.sq_res >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule
`default_nettype wire

### design/pgpc_front.sv
`default_nettype none
// Position/heading error, squares, arrival check, CORDIC seed.
module pgpc_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire pgpc_pkg::in_t   in_data,
  input  wire pgpc_pkg::cfg_t  cfg,
  output pgpc_pkg::cell_t      seed
);

  // stage A: errors
  logic               a_vld_r;
  logic signed [16:0] ex_r, ex_nxt;
  logic signed [16:0] ey_r, ey_nxt;
  logic signed [15:0] a_hd_r;
  logic signed [15:0] a_beta_r, a_beta_nxt;

  assign ex_nxt     = {cfg.goal_x[15], cfg.goal_x} - {in_data.pose_x[15], in_data.pose_x};
  assign ey_nxt     = {cfg.goal_y[15], cfg.goal_y} - {in_data.pose_y[15], in_data.pose_y};
  assign a_beta_nxt = cfg.goal_heading - in_data.pose_heading;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex_r     <= ex_nxt;
      ey_r     <= ey_nxt;
      a_hd_r   <= in_data.pose_heading;
      a_beta_r <= a_beta_nxt;
    end
  end

  // stage B: squares, tolerance check, CORDIC start point
  logic                           b_vld_r;
  logic [31:0]                    sqx_r, sqx_nxt;
  logic [31:0]                    sqy_r, sqy_nxt;
  logic signed [33:0]             sqx_full, sqy_full;
  logic signed [pgpc_pkg::CW-1:0] x0_r, x0_nxt;
  logic signed [pgpc_pkg::CW-1:0] y0_r, y0_nxt;
  logic [31:0]                    z0_r, z0_nxt;
  logic                           zero_r, zero_nxt;
  logic                           arr_r, arr_nxt;
  logic signed [15:0]             b_hd_r;
  logic signed [15:0]             b_beta_r;
  logic [16:0]                    aex, aey, abeta;
  logic signed [pgpc_pkg::CW-1:0] exs, eys;

  assign sqx_full = ex_r * ex_r;
  assign sqy_full = ey_r * ey_r;
  assign sqx_nxt  = sqx_full[31:0];
  assign sqy_nxt  = sqy_full[31:0];

  assign aex   = ex_r[16] ? 17'(-ex_r) : 17'(ex_r);
  assign aey   = ey_r[16] ? 17'(-ey_r) : 17'(ey_r);
  assign abeta = a_beta_r[15] ? (17'd0 - {a_beta_r[15], a_beta_r})
                              : {1'b0, a_beta_r};
  assign arr_nxt = (aex < {2'b00, cfg.position_tolerance}) &&
                   (aey < {2'b00, cfg.position_tolerance}) &&
                   (abeta < {2'b00, cfg.angle_tolerance});

  assign exs = {{(pgpc_pkg::CW-25){ex_r[16]}}, ex_r, 8'h00};
  assign eys = {{(pgpc_pkg::CW-25){ey_r[16]}}, ey_r, 8'h00};

  // left half plane: rotate by pi first
  always_comb begin
    if (ex_r[16]) begin
      x0_nxt = -exs;
      y0_nxt = -eys;
      z0_nxt = 32'h80000000;
    end else begin
      x0_nxt = exs;
      y0_nxt = eys;
      z0_nxt = 32'h00000000;
    end
  end

  assign zero_nxt = (ex_r == 17'sd0) && (ey_r == 17'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r    <= sqx_nxt;
      sqy_r    <= sqy_nxt;
      x0_r     <= x0_nxt;
      y0_r     <= y0_nxt;
      z0_r     <= z0_nxt;
      zero_r   <= zero_nxt;
      arr_r    <= arr_nxt;
      b_hd_r   <= a_hd_r;
      b_beta_r <= a_beta_r;
    end
  end

  always_comb begin
    seed.vld     = b_vld_r;
    seed.x       = x0_r;
    seed.y       = y0_r;
    seed.z       = z0_r;
    seed.sq_n    = {2'b00, sqx_r} + {2'b00, sqy_r};
    seed.sq_res  = '0;
    seed.heading = b_hd_r;
    seed.beta    = b_beta_r;
    seed.arrived = arr_r;
    seed.zero    = zero_r;
  end

endmodule
`default_nettype wire

### design/pgpc_back.sv
`default_nettype none
// Bearing rounding, gain products and saturation.
module pgpc_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire pgpc_pkg::cell_t cell_in,
  input  wire pgpc_pkg::cfg_t  cfg,
  output logic                 res_vld,
  output pgpc_pkg::out_t       res_data
);

  localparam logic signed [33:0] LIN_RND = 34'sd2048;
  localparam logic signed [33:0] LIN_MAX = 34'sd131071;
  localparam logic signed [65:0] ANG_RND = 66'sd8796093022208;
  localparam logic signed [65:0] ANG_MAX = 66'sd32767;
  localparam logic signed [65:0] ANG_MIN = -66'sd32768;

  // P1: bearing, alpha, distance product
  logic               p1_vld_r;
  logic [31:0]        z_adj, z_rnd;
  logic signed [15:0] alpha_nxt;
  logic signed [17:0] dist_s;
  logic signed [33:0] lin_prod_nxt;
  logic signed [15:0] p1_alpha_r, p1_beta_r;
  logic [16:0]        p1_dist_r;
  logic signed [33:0] p1_lin_prod_r;
  logic               p1_arr_r;

  assign z_adj        = cell_in.zero ? 32'h0 : cell_in.z;
  assign z_rnd        = z_adj + 32'h00008000;
  assign alpha_nxt    = $signed(z_rnd[31:16]) - cell_in.heading;
  assign dist_s       = {1'b0, cell_in.sq_res[16:0]};
  assign lin_prod_nxt = cfg.gain_rho * dist_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= cell_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_alpha_r    <= alpha_nxt;
      p1_beta_r     <= cell_in.beta;
      p1_dist_r     <= cell_in.sq_res[16:0];
      p1_lin_prod_r <= lin_prod_nxt;
      p1_arr_r      <= cell_in.arrived;
    end
  end

  // P2: angle products, linear saturation
  logic               p2_vld_r;
  logic signed [31:0] pa_nxt, pb_nxt, p2_pa_r, p2_pb_r;
  logic signed [33:0] lin_sh;
  logic [16:0]        lin_nxt, p2_lin_r;
  logic signed [15:0] p2_alpha_r, p2_beta_r;
  logic [16:0]        p2_dist_r;
  logic               p2_arr_r;

  assign pa_nxt = cfg.gain_alpha * p1_alpha_r;
  assign pb_nxt = cfg.gain_beta * p1_beta_r;
  assign lin_sh = (p1_lin_prod_r + LIN_RND) >>> 12;

  always_comb begin
    if (lin_sh[33]) begin
      lin_nxt = '0;
    end else if (lin_sh > LIN_MAX) begin
      lin_nxt = '1;
    end else begin
      lin_nxt = lin_sh[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_pa_r    <= pa_nxt;
      p2_pb_r    <= pb_nxt;
      p2_lin_r   <= lin_nxt;
      p2_alpha_r <= p1_alpha_r;
      p2_beta_r  <= p1_beta_r;
      p2_dist_r  <= p1_dist_r;
      p2_arr_r   <= p1_arr_r;
    end
  end

  // P3: angular sum
  logic               p3_vld_r;
  logic signed [32:0] s_nxt, p3_s_r;
  logic [16:0]        p3_lin_r;
  logic signed [15:0] p3_alpha_r, p3_beta_r;
  logic [16:0]        p3_dist_r;
  logic               p3_arr_r;

  assign s_nxt = {p2_pa_r[31], p2_pa_r} + {p2_pb_r[31], p2_pb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (en) begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_s_r     <= s_nxt;
      p3_lin_r   <= p2_lin_r;
      p3_alpha_r <= p2_alpha_r;
      p3_beta_r  <= p2_beta_r;
      p3_dist_r  <= p2_dist_r;
      p3_arr_r   <= p2_arr_r;
    end
  end

  // P4: sum times pi, split in two partial products
  logic               p4_vld_r;
  logic signed [16:0] s_hi, s_lo;
  logic signed [48:0] hi_p_nxt, lo_p_nxt, p4_hi_p_r, p4_lo_p_r;
  logic [16:0]        p4_lin_r;
  logic signed [15:0] p4_alpha_r, p4_beta_r;
  logic [16:0]        p4_dist_r;
  logic               p4_arr_r;

  assign s_hi     = p3_s_r[32:16];
  assign s_lo     = {1'b0, p3_s_r[15:0]};
  assign hi_p_nxt = s_hi * pgpc_pkg::PI_Q29;
  assign lo_p_nxt = s_lo * pgpc_pkg::PI_Q29;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_vld_r <= 1'b0;
    end else if (en) begin
      p4_vld_r <= p3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_hi_p_r  <= hi_p_nxt;
      p4_lo_p_r  <= lo_p_nxt;
      p4_lin_r   <= p3_lin_r;
      p4_alpha_r <= p3_alpha_r;
      p4_beta_r  <= p3_beta_r;
      p4_dist_r  <= p3_dist_r;
      p4_arr_r   <= p3_arr_r;
    end
  end

  // P5: recombine, round, saturate, arrival override
  logic signed [65:0] full, ang_sh;
  logic signed [15:0] ang;

  assign full   = ({{17{p4_hi_p_r[48]}}, p4_hi_p_r} << 16) +
                  {{17{p4_lo_p_r[48]}}, p4_lo_p_r} + ANG_RND;
  assign ang_sh = full >>> 44;

  always_comb begin
    if (ang_sh > ANG_MAX) begin
      ang = 16'sh7FFF;
    end else if (ang_sh < ANG_MIN) begin
      ang = -16'sh8000;
    end else begin
      ang = ang_sh[15:0];
    end
  end

  assign res_vld = p4_vld_r;

  always_comb begin
    res_data.linear_speed  = p4_arr_r ? 17'd0 : p4_lin_r;
    res_data.angular_speed = p4_arr_r ? 16'sd0 : ang;
    res_data.distance      = p4_dist_r;
    res_data.bearing_error = p4_alpha_r;
    res_data.heading_error = p4_beta_r;
    res_data.at_goal       = p4_arr_r;
  end

endmodule
`default_nettype wire

### design/polar_goal_pose_controller.sv
// Polar goal pose controller.
// Input channel (in_valid/in_stall/in_data): one measured pose per beat.
// Result channel (out_valid/out_stall/out_data): one command beat per pose,
// in order: linear and angular speed, distance, bearing and heading error,
// at_goal. Goal pose, gains and tolerances sit in eight registers written
// through cfg_we/cfg_index/cfg_data; the user must write them only while
// no pose is in flight, as the block itself does not enforce it.
// The depth is set by the cell row, where a cell does a CORDIC
// micro-rotation if its index is below CORDIC_STAGES and a square root
// digit if its index is below SQ_DIGITS, followed by the split pi multiply.
// Throughput: one pose per cycle while in_stall is low.
// Stall: an output register plus one skid register sit after the pipe.
// When both are full the whole pipe holds and in_stall is raised; in_stall
// comes straight from the skid flop. Nothing in flight is dropped.
// Reset (rst_n low, synchronous): pipe and output emptied, registers back
// to goal at origin, gains 0.15/0.4/-0.15, tolerances 102 and one radian.
`default_nettype none
`include "polar_goal_pose_controller_macros.svh"
module polar_goal_pose_controller #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire pgpc_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output pgpc_pkg::out_t       out_data,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [15:0]     cfg_data
);

  localparam int NCELL = (CORDIC_STAGES > pgpc_pkg::SQ_DIGITS) ?
                         CORDIC_STAGES : pgpc_pkg::SQ_DIGITS;

  // ---------------- configuration registers ----------------
  pgpc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.goal_x             <= '0;
      cfg_r.goal_y             <= '0;
      cfg_r.goal_heading       <= '0;
      cfg_r.gain_rho           <= pgpc_pkg::RST_GAIN_RHO;
      cfg_r.gain_alpha         <= pgpc_pkg::RST_GAIN_ALPHA;
      cfg_r.gain_beta          <= pgpc_pkg::RST_GAIN_BETA;
      cfg_r.position_tolerance <= pgpc_pkg::RST_POS_TOL;
      cfg_r.angle_tolerance    <= pgpc_pkg::RST_ANG_TOL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pgpc_pkg::REG_GOAL_X:       cfg_r.goal_x             <= cfg_data;
        pgpc_pkg::REG_GOAL_Y:       cfg_r.goal_y             <= cfg_data;
        pgpc_pkg::REG_GOAL_HEADING: cfg_r.goal_heading       <= cfg_data;
        pgpc_pkg::REG_GAIN_RHO:     cfg_r.gain_rho           <= cfg_data;
        pgpc_pkg::REG_GAIN_ALPHA:   cfg_r.gain_alpha         <= cfg_data;
        pgpc_pkg::REG_GAIN_BETA:    cfg_r.gain_beta          <= cfg_data;
        pgpc_pkg::REG_POS_TOL:      cfg_r.position_tolerance <= cfg_data[14:0];
        pgpc_pkg::REG_ANG_TOL:      cfg_r.angle_tolerance    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipe ----------------
  // whole pipe advances unless the skid slot is occupied
  logic adv;
  logic skid_valid_r;

  assign adv      = !skid_valid_r;
  assign in_stall = skid_valid_r;

  pgpc_pkg::cell_t chain [0:NCELL];

  pgpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .seed     (chain[0])
  );

  // row of cells: CORDIC micro-rotation i below CORDIC_STAGES, square root digit i below SQ_DIGITS
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    pgpc_cell #(
      .IDX    (i),
      .ROT_EN (i < CORDIC_STAGES)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  logic           res_vld;
  pgpc_pkg::out_t res_data;

  pgpc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .cell_in  (chain[NCELL]),
    .cfg      (cfg_r),
    .res_vld  (res_vld),
    .res_data (res_data)
  );

  // ---------------- output register + skid ----------------
  logic           out_valid_r;
  pgpc_pkg::out_t out_data_r;
  pgpc_pkg::out_t skid_data_r;
  logic           take;

  assign take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // pipe frozen: drain skid into output once the beat goes
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_vld) begin
      if (out_valid_r && !take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_data_r <= skid_data_r;
      end
    end else if (res_vld) begin
      if (out_valid_r && !take) begin
        skid_data_r <= res_data;
      end else begin
        out_data_r <= res_data;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- checks ----------------
  `PGPC_ASSERT(a_skid_needs_out, clk, rst_n, skid_valid_r |-> out_valid_r)
  `PGPC_ASSERT(a_stall_from_out, clk, rst_n, $rose(in_stall) |-> $past(out_valid && out_stall))
  `PGPC_ASSERT_RST(a_reset_empties, clk, !rst_n |=> (!out_valid && !in_stall))

endmodule
`default_nettype wire
